### hdl/assert_macros.svh
// assertion macros used by the port-level checker in hdl/vvpi_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/vvpi_pkg.sv
// shared constants and types of the vertical velocity pi controller
// no dependencies
package vvpi_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgIdxW = 3;

  // velocity error deadband, just under 0.15 in q16.16
  localparam logic signed [31:0] Deadband    = 32'sd9830;
  // integral clamp, 40.0 in q16.16
  localparam logic signed [32:0] IntegralMax = 33'sd2621440;
  // rounding bias for the q16.16 product shift
  localparam logic [33:0] RoundBias = 34'h0_0000_8000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_LIM = 3'd2,
    REG_DT  = 3'd3
  } reg_idx_e;

  localparam logic [15:0] DtReset = 16'd655;

endpackage

### hdl/vvpi_mul.sv
// digit-serial q16.16 multiplier: gain * x, rounded half away from zero, saturated
// depends on vvpi_pkg
module vvpi_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [vvpi_pkg::DataW-1:0]        gain_i,
  input  logic signed [vvpi_pkg::DataW:0]   x_i,
  output logic                              done_o,
  output logic signed [vvpi_pkg::DataW-1:0] prod_o
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LOAD = 4'b0010,
    M_RUN  = 4'b0100,
    M_FIN  = 4'b1000
  } mul_state_e;

  mul_state_e  state_q, state_d;
  logic [31:0] g_q;
  logic [33:0] g3_q;
  logic [33:0] hi_q;
  logic [31:0] lo_q;
  logic        neg_q;
  logic [3:0]  cnt_q;
  logic        done_q;
  logic signed [31:0] prod_q;

  logic [32:0] mag_x;
  logic [33:0] pp;
  logic [34:0] sum;
  logic [47:0] shifted;
  logic        over;
  logic [31:0] mag_r;
  logic [31:0] res;

  // magnitude of the operand at capture
  assign mag_x = x_i[32] ? 33'(-x_i) : 33'(x_i);

  // partial product for the current 2-bit digit
  always_comb begin
    unique case (lo_q[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = {2'b00, g_q};
      2'd2:    pp = {1'b0, g_q, 1'b0};
      default: pp = g3_q;
    endcase
  end

  assign sum = {1'b0, hi_q} + {1'b0, pp};

  // shift right by 16 and saturate magnitude, then apply the sign
  always_comb begin
    shifted = {hi_q[31:0], lo_q[31:16]};
    over    = (|shifted[47:32]) || (shifted[31] && (|shifted[30:0]));
    mag_r   = over ? 32'h8000_0000 : shifted[31:0];
    if (!neg_q && mag_r[31]) begin
      mag_r = 32'h7FFF_FFFF;
    end
    res = neg_q ? 32'(-mag_r) : mag_r;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: if (start_i) state_d = M_LOAD;
      M_LOAD: state_d = M_RUN;
      M_RUN:  if (cnt_q == 4'd15) state_d = M_FIN;
      M_FIN:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_FIN);
      if (state_q == M_LOAD) begin
        cnt_q <= '0;
      end else if (state_q == M_RUN) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  // datapath: the rounding bias rides in the initial high word
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          g_q   <= gain_i;
          hi_q  <= vvpi_pkg::RoundBias;
          lo_q  <= mag_x[31:0];
          neg_q <= x_i[32];
        end
      end
      M_LOAD: g3_q <= {2'b00, g_q} + {1'b0, g_q, 1'b0};
      M_RUN: begin
        hi_q <= {1'b0, sum[34:2]};
        lo_q <= {sum[1:0], lo_q[31:2]};
      end
      M_FIN:  prod_q <= res;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

### hdl/vertical_velocity_pi_controller.sv
// top level of the vertical velocity pi controller
// depends on vvpi_pkg and vvpi_mul
//
// One tick in, one thrust correction out, one tick at a time. A flying tick
// runs three rounds of q16.16 multiplications back to back on two digit-serial
// multipliers that take 2 bits per cycle (step and proportional term in
// parallel, then the integral term on the tentative and on the final
// integral); a grounded tick skips them. A new tick is accepted once the
// result has moved from the result register into the output register,
// while that result still waits on the output. The low saturation value
// -(2*limit+2)/5 comes from a bit-serial divider that runs alongside.
// Configuration writes are always ready and must be made while the block is idle.
module vertical_velocity_pi_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [vvpi_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] target_velocity, [63:32] measured_velocity
  input  logic        s_axis_tuser,   // [0] flying
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] thrust_correction
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_ERR  = 11'b000_0000_0010,
    S_M1GO = 11'b000_0000_0100,
    S_M1   = 11'b000_0000_1000,
    S_M2GO = 11'b000_0001_0000,
    S_M2   = 11'b000_0010_0000,
    S_INT  = 11'b000_0100_0000,
    S_M3GO = 11'b000_1000_0000,
    S_M3   = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } ctl_state_e;

  ctl_state_e state_q, state_d;

  // configuration registers
  logic [31:0] kp_q, ki_q;
  logic [30:0] lim_q;
  logic [15:0] dt_q;

  // datapath registers
  logic signed [31:0] tgt_q, meas_q, err_q;
  logic signed [32:0] tent_q, u_q;
  logic signed [31:0] pterm_q, integral_q, res_q;
  logic               m_valid_q;
  logic [31:0]        m_data_q;

  // serial divide-by-five of the low bound
  logic [32:0] div_q;
  logic [2:0]  rem_q;
  logic [5:0]  div_cnt_q;
  logic [3:0]  div_r;
  logic        div_ge;
  logic        div_busy;

  // multiplier hookup
  logic        start_a, start_b, done_a, done_b;
  logic [31:0] gain_a;
  logic signed [32:0] x_a, x_b;
  logic signed [31:0] prod_a, prod_b;

  logic        in_acc, out_free;
  logic signed [32:0] diff, lim_s, sel, sum_u;
  logic signed [31:0] err_sat;
  logic        band_out;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign lim_s = {2'b00, lim_q};

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      lim_q <= '0;
      dt_q  <= vvpi_pkg::DtReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        vvpi_pkg::REG_KP:  kp_q  <= cfg_data_i;
        vvpi_pkg::REG_KI:  ki_q  <= cfg_data_i;
        vvpi_pkg::REG_LIM: lim_q <= cfg_data_i[30:0];
        vvpi_pkg::REG_DT:  dt_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // saturated error with deadband
  always_comb begin
    diff = 33'(tgt_q) - 33'(meas_q);
    if (diff[32] != diff[31]) begin
      err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = diff[31:0];
    end
    if (err_sat <= vvpi_pkg::Deadband && err_sat >= -vvpi_pkg::Deadband) begin
      err_sat = '0;
    end
  end

  // multiplier operand selection
  assign start_a = (state_q == S_M1GO) || (state_q == S_M2GO) || (state_q == S_M3GO);
  assign start_b = (state_q == S_M1GO);
  assign x_b     = 33'(err_q);
  always_comb begin
    gain_a = ki_q;
    x_a    = 33'(integral_q);
    if (state_q == S_M1GO) begin
      gain_a = {16'd0, dt_q};
      x_a    = 33'(err_q);
    end else if (state_q == S_M2GO) begin
      x_a    = tent_q;
    end
  end

  vvpi_mul u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_a),
    .gain_i  (gain_a),
    .x_i     (x_a),
    .done_o  (done_a),
    .prod_o  (prod_a)
  );

  vvpi_mul u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_b),
    .gain_i  (kp_q),
    .x_i     (x_b),
    .done_o  (done_b),
    .prod_o  (prod_b)
  );

  // anti-windup decision and integral clamp
  assign sum_u = 33'(pterm_q) + 33'(prod_a);
  always_comb begin
    band_out = (u_q > lim_s) || (u_q < -lim_s);
    sel = band_out ? 33'(integral_q) : tent_q;
    if (sel > vvpi_pkg::IntegralMax) begin
      sel = vvpi_pkg::IntegralMax;
    end else if (sel < -vvpi_pkg::IntegralMax) begin
      sel = -vvpi_pkg::IntegralMax;
    end
  end

  // divider step
  assign div_r    = {rem_q, div_q[32]};
  assign div_ge   = (div_r >= 4'd5);
  assign div_busy = (div_cnt_q != '0);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = s_axis_tuser ? S_ERR : S_OUT;
      S_ERR:  state_d = S_M1GO;
      S_M1GO: state_d = S_M1;
      S_M1:   if (done_a && done_b) state_d = S_M2GO;
      S_M2GO: state_d = S_M2;
      S_M2:   if (done_a) state_d = S_INT;
      S_INT:  state_d = S_M3GO;
      S_M3GO: state_d = S_M3;
      S_M3:   if (done_a) state_d = S_FIN;
      S_FIN:  if (!div_busy) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      integral_q <= '0;
      div_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (in_acc && !s_axis_tuser) begin
        integral_q <= '0;
      end else if (state_q == S_INT) begin
        integral_q <= sel[31:0];
      end
      if (in_acc) begin
        div_cnt_q <= 6'd33;
      end else if (div_busy) begin
        div_cnt_q <= div_cnt_q - 6'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q  <= s_axis_tdata[31:0];
      meas_q <= s_axis_tdata[63:32];
      res_q  <= '0;
      div_q  <= {1'b0, lim_q, 1'b0} + 33'd2;
      rem_q  <= '0;
    end else if (div_busy) begin
      div_q  <= {div_q[31:0], div_ge};
      rem_q  <= div_ge ? 3'(div_r - 4'd5) : div_r[2:0];
    end
    if (state_q == S_ERR) begin
      err_q <= err_sat;
    end
    if (state_q == S_M1 && done_a) begin
      tent_q  <= 33'(integral_q) + 33'(prod_a);
      pterm_q <= prod_b;
    end
    if ((state_q == S_M2 || state_q == S_M3) && done_a) begin
      u_q <= sum_u;
    end
    if (state_q == S_FIN && !div_busy) begin
      if (u_q > lim_s) begin
        res_q <= {1'b0, lim_q};
      end else if (u_q < -lim_s) begin
        res_q <= -div_q[31:0];
      end else begin
        res_q <= u_q[31:0];
      end
    end
    if (state_q == S_OUT && out_free) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### hdl/vvpi_checker.sv
// port-level checker for the vertical velocity pi controller, with its bind
// depends on assert_macros.svh
`include "assert_macros.svh"

module vvpi_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;
  // grounded flag of each pending transaction, bit 0 the oldest
  logic [1:0] gnd_q, gnd_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // shift out the leaving transaction, append the arriving one
  always_comb begin
    gnd_d = gnd_q;
    if (out_acc) begin
      gnd_d = {1'b0, gnd_q[1]};
    end
    if (in_acc) begin
      if (pend_q == 2'd0 || (pend_q == 2'd1 && out_acc)) begin
        gnd_d[0] = !s_axis_tuser;
      end else begin
        gnd_d[1] = !s_axis_tuser;
      end
    end
  end

  // items taken whose result has not left yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      gnd_q  <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
      gnd_q  <= gnd_d;
    end
  end

  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_acc, !s_axis_tready)
  `ASSERT_SAME(a_no_invented, clk_i, rst_ni, m_axis_tvalid, pend_q != 2'd0)
  `ASSERT_SAME(a_no_overrun, clk_i, rst_ni, in_acc, pend_q != 2'd2)
  `ASSERT_SAME(a_grounded_zero, clk_i, rst_ni, out_acc && gnd_q[0], m_axis_tdata == 32'd0)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind vertical_velocity_pi_controller vvpi_port_checker u_vvpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/vvpi_checker.sv
`timescale 1ns / 100ps
// checker for the vertical velocity pi controller: follows register writes,
// tick and result transactions, predicts each thrust correction and compares
// depends on vvpi_pkg for the register indexes
module vvpi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [vvpi_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          tick_valid_i,
  input  logic                          tick_ready_i,
  input  logic [63:0]                   tick_data_i,   // [31:0] target, [63:32] measured
  input  logic                          tick_user_i,   // [0] flying
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [31:0]                   res_data_i,    // [31:0] thrust_correction
  output logic [31:0]                   outstanding_o,
  output logic [31:0]                   errors_o
);

  localparam longint DeadbandQ16      = 9830;
  localparam longint IntegralClampQ16 = 2621440;
  localparam longint S32Max           = 64'sd2147483647;
  localparam longint S32Min           = -64'sd2147483648;
  localparam logic [15:0] DtResetQ16  = 16'd655;

  // controller settings and integrator as the block should hold them
  logic [31:0]        kp_q;
  logic [31:0]        ki_q;
  logic [30:0]        lim_q;
  logic [15:0]        dt_q;
  logic signed [31:0] integ_q;

  logic [31:0] thrust_q[$];
  int unsigned results_seen;
  int unsigned mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic flag_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic longint clamp_s32(input longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  // gain * x in q16.16, rounded half away from zero, saturated to 32 bits
  function automatic longint scale_q16(input logic [31:0] gain, input longint x);
    longint      amag;
    logic [31:0] mag;
    logic [64:0] prod;
    longint      r;
    amag = (x < 0) ? -x : x;
    mag  = (amag > 64'sd4294967295) ? 32'hFFFF_FFFF : amag[31:0];
    prod = ({33'd0, gain} * {33'd0, mag} + 65'h8000) >> 16;
    if (prod > 65'h8000_0000) prod = 65'h8000_0000;
    r = longint'(prod[63:0]);
    return clamp_s32((x < 0) ? -r : r);
  endfunction

  // one control tick: returns the thrust, hands back the new integral
  function automatic logic [31:0] predict_thrust(input logic [31:0] tgt,
                                                 input logic [31:0] meas,
                                                 input logic fly,
                                                 input logic signed [31:0] integ_cur,
                                                 output logic signed [31:0] integ_next);
    longint err, step, tent, pterm, u, lim, integ;
    integ_next = '0;
    if (!fly) return 32'd0;
    lim = longint'({1'b0, lim_q});
    err = clamp_s32(longint'($signed(tgt)) - longint'($signed(meas)));
    if (err <= DeadbandQ16 && err >= -DeadbandQ16) err = 0;
    step  = scale_q16({16'd0, dt_q}, err);
    tent  = longint'(integ_cur) + step;
    pterm = scale_q16(kp_q, err);
    // conditional integration: keep the old integral if the tentative output saturates
    u     = pterm + scale_q16(ki_q, tent);
    integ = (u > lim || u < -lim) ? longint'(integ_cur) : tent;
    if (integ > IntegralClampQ16) integ = IntegralClampQ16;
    if (integ < -IntegralClampQ16) integ = -IntegralClampQ16;
    integ_next = integ[31:0];
    // asymmetric output clamp
    u = pterm + scale_q16(ki_q, integ);
    if (u > lim) u = lim;
    if (u < -lim) u = -((2 * lim + 2) / 5);
    return u[31:0];
  endfunction

  // follow every transaction on the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0]        want;
    logic signed [31:0] integ_nx;
    if (!rst_ni) begin
      kp_q          <= '0;
      ki_q          <= '0;
      lim_q         <= '0;
      dt_q          <= DtResetQ16;
      integ_q       <= '0;
      outstanding_o <= '0;
      results_seen  <= 0;
      thrust_q.delete();
    end else begin
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          vvpi_pkg::REG_KP:  kp_q  <= cfg_data_i;
          vvpi_pkg::REG_KI:  ki_q  <= cfg_data_i;
          vvpi_pkg::REG_LIM: lim_q <= cfg_data_i[30:0];
          vvpi_pkg::REG_DT:  dt_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (res_valid_i && res_ready_i) begin
        results_seen <= results_seen + 1;
        if (thrust_q.size() == 0) begin
          flag_error($sformatf("thrust result %h arrived with no tick waiting", res_data_i));
        end else begin
          want = thrust_q.pop_front();
          if (res_data_i !== want)
            flag_error($sformatf("thrust mismatch on result %0d: got %h, expected %h",
                                 results_seen, res_data_i, want));
        end
      end
      // tick transaction
      if (tick_valid_i && tick_ready_i) begin
        want = predict_thrust(tick_data_i[31:0], tick_data_i[63:32], tick_user_i,
                              integ_q, integ_nx);
        integ_q <= integ_nx;
        thrust_q.push_back(want);
      end
      outstanding_o <= thrust_q.size();
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the vertical velocity pi controller: clock, reset,
// tick stimulus, register writes and receiver stalls; vvpi_checker compares
// depends on vvpi_pkg, vvpi_checker and the controller rtl
module tb_top;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 100;
  localparam int unsigned RandomTicks = 750;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [31:0] VelMax = 32'h7FFF_FFFF;
  localparam logic [31:0] VelMin = 32'h8000_0000;
  localparam logic [31:0] LimMax = 32'h7FFF_FFFF;
  localparam logic [31:0] DtMax  = 32'h0000_FFFF;
  localparam logic Airborne = 1'b1;
  localparam logic Grounded = 1'b0;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TRICKLE, RX_PULSED} rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [vvpi_pkg::CfgIdxW-1:0]  cfg_addr_i;
  logic [31:0]                   cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [63:0]                   s_axis_tdata;   // [31:0] target_velocity, [63:32] measured_velocity
  logic                          s_axis_tuser;   // [0] flying
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;   // [31:0] thrust_correction
  logic [31:0]                   outstanding;
  logic [31:0]                   errors;
  int unsigned                   burst_left = 0;

  vertical_velocity_pi_controller uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  vvpi_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .tick_user_i  (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .outstanding_o(outstanding),
    .errors_o     (errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver back-pressure in one of four modes that change at random
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_count = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_count <= rx_count + 1;
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
      RX_TRICKLE: m_axis_tready <= (rx_count % 13) == 0;
      default:    m_axis_tready <= rx_count[5];
    endcase
  end

  // watchdog on cycles without any transaction
  wire any_transaction = (cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
                         (m_axis_tvalid && m_axis_tready);

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (any_transaction) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // one tick transaction; the sender runs in bursts with gaps between them
  task automatic send_tick(input logic [31:0] tgt, input logic [31:0] meas, input logic fly);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, tgt};
    s_axis_tuser  <= fly;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      gap = $urandom_range(1, 24);
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // hold off the sender until every predicted thrust has been received
  task automatic wait_results_in();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // write all four registers while idle, optionally with unused indexes first
  task automatic retune(input logic [31:0] kp, input logic [31:0] ki,
                        input logic [31:0] lim, input logic [31:0] dt, input bit junk);
    logic [vvpi_pkg::CfgIdxW-1:0] addr_list[$];
    logic [31:0]                  data_list[$];
    wait_results_in();
    if (junk) begin
      for (int a = int'(vvpi_pkg::REG_DT) + 1; a < (1 << vvpi_pkg::CfgIdxW); a++) begin
        addr_list.push_back(a[vvpi_pkg::CfgIdxW-1:0]);
        data_list.push_back($urandom);
      end
    end
    addr_list.push_back(vvpi_pkg::REG_KP);
    data_list.push_back(kp);
    addr_list.push_back(vvpi_pkg::REG_KI);
    data_list.push_back(ki);
    addr_list.push_back(vvpi_pkg::REG_LIM);
    data_list.push_back(lim);
    addr_list.push_back(vvpi_pkg::REG_DT);
    data_list.push_back(dt);
    foreach (addr_list[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= addr_list[i];
      cfg_data_i  <= data_list[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // velocity: mostly within +/-10 m/s, sometimes any word
  function automatic logic [31:0] pick_velocity();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 1310720)) - 655360);
  endfunction

  // velocity error held over a run of ticks
  function automatic logic [31:0] pick_error();
    case ($urandom_range(0, 5))
      0:       return 32'(int'($urandom_range(0, 4)) + 9828);
      1:       return 32'(-(int'($urandom_range(0, 4)) + 9828));
      2:       return 32'(int'($urandom_range(0, 6553600)) - 3276800);
      default: return 32'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] kp, ki, lim, dt, tgt, bias, meas, noise;
    int unsigned random_sent, phase_len, sent, run_len;
    random_sent  = 0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_addr_i   = '0;
    cfg_data_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero gains and limit give zero thrust
    send_tick(VelMax, VelMin, Airborne);
    send_tick(OneQ16, 32'd0, Airborne);

    // moderate gains: deadband edges, saturating errors, grounded tick
    retune(32'h0002_0000, OneQ16, 32'd20 << 16, 32'd655, 1'b1);
    send_tick(32'd0, 32'd0, Airborne);
    send_tick(32'd9830, 32'd0, Airborne);
    send_tick(32'd0, 32'd9830, Airborne);
    send_tick(32'd9831, 32'd0, Airborne);
    send_tick(32'd0, 32'd9831, Airborne);
    send_tick(32'd5 << 16, 32'd0, Airborne);
    send_tick(32'd5 << 16, 32'd0, Airborne);
    send_tick(VelMax, VelMin, Airborne);
    send_tick(VelMin, VelMax, Airborne);
    send_tick(VelMax, VelMin, Grounded);
    send_tick(32'd5 << 16, 32'd0, Airborne);

    // long period, weak integral gain: integral hits its clamp both ways
    retune(32'd0, 32'h0000_0100, LimMax, DtMax, 1'b0);
    repeat (3) send_tick(32'd100 << 16, 32'd0, Airborne);
    repeat (3) send_tick(32'(-(32'sd100 <<< 16)), 32'd0, Airborne);

    // zero limit: every nonzero drive clamps to zero
    retune(OneQ16, OneQ16, 32'd0, 32'd655, 1'b0);
    send_tick(32'd3 << 16, 32'd0, Airborne);
    send_tick(32'd0, 32'd3 << 16, Airborne);

    // everything at its maximum
    retune(32'hFFFF_FFFF, 32'hFFFF_FFFF, LimMax, DtMax, 1'b0);
    send_tick(VelMax, VelMin, Airborne);
    send_tick(VelMin, VelMax, Airborne);

    // random phases of flight runs with some noise ticks
    while (random_sent < RandomTicks) begin
      case ($urandom_range(0, 9))
        0: begin
          kp = 32'hFFFF_FFFF; ki = 32'hFFFF_FFFF; lim = LimMax; dt = DtMax;
        end
        1: begin
          kp = '0; ki = '0; lim = '0; dt = '0;
        end
        2: begin
          kp = $urandom; ki = $urandom; lim = $urandom; dt = $urandom;
        end
        default: begin
          kp  = $urandom_range(0, 32'h0008_0000);
          ki  = $urandom_range(0, 32'h0004_0000);
          lim = $urandom_range(32'h0001_0000, 32'h0100_0000);
          case ($urandom_range(0, 2))
            0:       dt = 32'd655;
            1:       dt = 32'h0000_4000;
            default: dt = $urandom_range(1, 16'hFFFF);
          endcase
        end
      endcase
      retune(kp, ki, lim, dt, $urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 120);
      if (phase_len > RandomTicks - random_sent) phase_len = RandomTicks - random_sent;
      sent = 0;
      while (sent < phase_len) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick($urandom, $urandom, 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          if ($urandom_range(0, 7) == 0) begin
            send_tick(pick_velocity(), pick_velocity(), Grounded);
            sent++;
          end
          run_len = $urandom_range(1, 40);
          tgt  = pick_velocity();
          bias = pick_error();
          repeat (run_len) begin
            noise = ($urandom_range(0, 1) == 0) ? 32'd0 :
                    32'(int'($urandom_range(0, 13108)) - 6554);
            meas = tgt - bias + noise;
            send_tick(tgt, meas, Airborne);
            sent++;
          end
        end
        if ($urandom_range(0, 15) == 0) wait_results_in();
      end
      random_sent += sent;
    end

    // drain, let the block settle, then give the verdict
    wait_results_in();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### vertical_velocity_pi_controller.f
+incdir+hdl
hdl/vvpi_pkg.sv
hdl/vvpi_mul.sv
hdl/vertical_velocity_pi_controller.sv
hdl/vvpi_checker.sv
verif/vvpi_checker.sv
verif/tb_top.sv
